@@ hw/rtl/lcr_pkg.sv @@
package lcr_pkg;

  localparam int NODE_W = 9;

  localparam logic FUNC_SET     = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] resolved_node;
    logic              error;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;
    logic accept;
    logic eval;
    logic fin;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic in_resolve;
    logic in_node_ok;
    logic ev_stop;
    logic ev_next_bad;
    logic fin_done;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/lcr_datapath.sv @@
module lcr_datapath #(
  parameter int ENTRIES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lcr_pkg::cmd_t                  cmd,
  output lcr_pkg::status_t               stat,
  input  lcr_pkg::in_item_t              in_data,
  input  logic [lcr_pkg::NODE_W-1:0]     node_count,
  output logic                           out_valid,
  output lcr_pkg::out_item_t             out_data,
  input  logic                           out_stall
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam int PLW  = IDXW + 1;

  // Link table, error marks and visited marks share one read address and one write address.
  logic [lcr_pkg::NODE_W-1:0] link_mem [ENTRIES];
  logic                       err_mem  [ENTRIES];
  logic                       vis_mem  [ENTRIES];
  logic [IDXW-1:0]            path_mem [ENTRIES];

  logic [lcr_pkg::NODE_W-1:0] link_q;
  logic                       err_q;
  logic                       vis_q;
  logic [IDXW-1:0]            path_q;

  logic [IDXW-1:0]            rd_addr;
  logic [IDXW-1:0]            wr_addr;
  logic                       link_we;
  logic [lcr_pkg::NODE_W-1:0] link_wd;
  logic                       err_we;
  logic                       err_wd;
  logic                       vis_we;
  logic                       vis_wd;
  logic                       path_we;

  logic [lcr_pkg::NODE_W-1:0] cur_r;
  logic [lcr_pkg::NODE_W-1:0] answer_r;
  logic [PLW-1:0]             plen_r;
  logic [PLW-1:0]             fin_k_r;
  logic                       pend_r;
  logic                       failed_r;
  logic [IDXW-1:0]            clr_idx_r;
  logic                       out_valid_r;
  lcr_pkg::out_item_t         out_data_r;

  logic [lcr_pkg::NODE_W-1:0] count_act;
  logic [lcr_pkg::NODE_W-1:0] in_m1;
  logic [lcr_pkg::NODE_W-1:0] cur_m1;
  logic [lcr_pkg::NODE_W-1:0] link_m1;
  logic [IDXW-1:0]            in_idx;
  logic [IDXW-1:0]            cur_idx;
  logic [IDXW-1:0]            link_idx;
  logic                       in_ok;
  logic                       next_ok;
  logic                       ev_ok;
  logic                       ev_fail;
  logic                       ev_stop;
  logic                       fin_issue;

  function automatic logic node_ok(input logic [lcr_pkg::NODE_W-1:0] v,
                                   input logic [lcr_pkg::NODE_W-1:0] cnt);
    return (v != '0) && (v <= cnt);
  endfunction

  // Nodes above the table depth are out of range.
  assign count_act = (32'(node_count) > ENTRIES) ? lcr_pkg::NODE_W'(ENTRIES) : node_count;

  assign in_m1    = in_data.node - lcr_pkg::NODE_W'(1);
  assign cur_m1   = cur_r - lcr_pkg::NODE_W'(1);
  assign link_m1  = link_q - lcr_pkg::NODE_W'(1);
  assign in_idx   = IDXW'(in_m1);
  assign cur_idx  = IDXW'(cur_m1);
  assign link_idx = IDXW'(link_m1);

  assign in_ok   = node_ok(in_data.node, count_act);
  assign next_ok = node_ok(link_q, count_act);

  assign ev_ok   = !err_q && (link_q == '0);
  assign ev_fail = err_q || ((link_q != '0) &&
                   ((link_q == cur_r) || vis_q || (plen_r == PLW'(ENTRIES))));
  assign ev_stop = ev_ok || ev_fail;

  assign fin_issue = fin_k_r < plen_r;

  assign stat.clr_done    = clr_idx_r == IDXW'(ENTRIES - 1);
  assign stat.in_resolve  = in_data.func == lcr_pkg::FUNC_RESOLVE;
  assign stat.in_node_ok  = in_ok;
  assign stat.ev_stop     = ev_stop;
  assign stat.ev_next_bad = !ev_stop && !next_ok;
  assign stat.fin_done    = !fin_issue && !pend_r;
  assign stat.out_free    = !out_valid_r || !out_stall;

  // The walk reads the node it is about to visit; the first read comes with the transfer.
  assign rd_addr = cmd.accept ? in_idx : link_idx;

  assign path_we = cmd.eval && !ev_stop;

  always_comb begin
    wr_addr = '0;
    link_we = 1'b0;
    link_wd = '0;
    err_we  = 1'b0;
    err_wd  = 1'b0;
    vis_we  = 1'b0;
    vis_wd  = 1'b0;
    if (cmd.clr) begin
      wr_addr = clr_idx_r;
      link_we = 1'b1;
      err_we  = 1'b1;
      vis_we  = 1'b1;
    end else if (cmd.accept && (in_data.func == lcr_pkg::FUNC_SET) && in_ok) begin
      wr_addr = in_idx;
      link_we = 1'b1;
      link_wd = in_data.target;
      err_we  = 1'b1;
    end else if (cmd.eval && !ev_stop) begin
      wr_addr = cur_idx;
      vis_we  = 1'b1;
      vis_wd  = 1'b1;
    end else if (cmd.fin && pend_r) begin
      // Compression pass: point the node at the answer, or mark it on failure.
      wr_addr = path_q;
      vis_we  = 1'b1;
      if (failed_r) begin
        err_we = 1'b1;
        err_wd = 1'b1;
      end else begin
        link_we = 1'b1;
        link_wd = answer_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[wr_addr] <= link_wd;
    end
    if (err_we) begin
      err_mem[wr_addr] <= err_wd;
    end
    if (vis_we) begin
      vis_mem[wr_addr] <= vis_wd;
    end
    link_q <= link_mem[rd_addr];
    err_q  <= err_mem[rd_addr];
    vis_q  <= vis_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (path_we) begin
      path_mem[plen_r[IDXW-1:0]] <= cur_idx;
    end
    path_q <= path_mem[fin_k_r[IDXW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      plen_r      <= '0;
      fin_k_r     <= '0;
      pend_r      <= 1'b0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + IDXW'(1);
      end
      if (cmd.accept) begin
        plen_r   <= '0;
        fin_k_r  <= '0;
        pend_r   <= 1'b0;
        failed_r <= !in_ok;
      end
      if (cmd.eval) begin
        if (ev_fail) begin
          failed_r <= 1'b1;
        end else if (!ev_ok) begin
          plen_r <= plen_r + PLW'(1);
          if (!next_ok) begin
            failed_r <= 1'b1;
          end
        end
      end
      if (cmd.fin) begin
        if (fin_issue) begin
          fin_k_r <= fin_k_r + PLW'(1);
        end
        pend_r <= fin_issue;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r <= in_data.node;
    end
    if (cmd.eval) begin
      if (ev_ok) begin
        answer_r <= cur_r;
      end else if (!ev_fail) begin
        cur_r <= link_q;
      end
    end
    if (cmd.push) begin
      if (failed_r) begin
        out_data_r.resolved_node <= '0;
        out_data_r.error         <= 1'b1;
      end else begin
        out_data_r.resolved_node <= answer_r;
        out_data_r.error         <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/lcr_ctrl.sv @@
module lcr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lcr_pkg::status_t stat,
  output lcr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    EVAL,
    FIN,
    PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   in_stall_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = IDLE;
        end
      end
      IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.accept = 1'b1;
          if (stat.in_resolve) begin
            state_nxt = stat.in_node_ok ? EVAL : FIN;
          end
        end
      end
      EVAL: begin
        cmd.eval = 1'b1;
        if (stat.ev_stop || stat.ev_next_bad) begin
          state_nxt = FIN;
        end
      end
      FIN: begin
        cmd.fin = 1'b1;
        if (stat.fin_done) begin
          state_nxt = PUSH;
        end
      end
      PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: begin
        state_nxt = CLEAR;
      end
    endcase
  end

  assign in_stall_nxt = state_nxt != IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CLEAR;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

@@ hw/rtl/link_chain_resolver_core.sv @@
// Link chain resolver: a table of node links with path compression.
// Input channel (in_valid/in_stall/in_data) takes one item per transfer.
// A set item for an in-range node writes one link and clears that node's
// error mark; it gives no result. A resolve item walks the links from the
// given node one table read per cycle, then rewrites every node on the
// path, one per cycle, and gives one result on the output channel.
// A path holds at most ENTRIES nodes. The result register lets the next
// item be taken while a result waits; if out_stall holds a result, a
// finished resolve waits before it loads. After reset a clearing pass
// empties the table while in_stall stays high; configuration writes are
// taken at any time. node_count sits at byte address 0 of the APB port
// and resets to 256.
module link_chain_resolver_core #(
  parameter int ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lcr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lcr_pkg::out_item_t            out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [lcr_pkg::NODE_W-1:0] node_count_r;
  logic                       cfg_wr;
  lcr_pkg::cmd_t              cmd;
  lcr_pkg::status_t           stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= lcr_pkg::NODE_W'(256);
    end else if (cfg_wr && (cfg_paddr[2] == 1'b0)) begin
      node_count_r <= cfg_pwdata[lcr_pkg::NODE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ?
                      {{(32 - lcr_pkg::NODE_W){1'b0}}, node_count_r} : 32'd0;

  lcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcr_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .node_count (node_count_r),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

`ifndef SYNTHESIS
  // The clearing pass holds off input right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  // An error result never carries a node number, and a good one always does.
  a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.error ? (out_data.resolved_node == '0)
                                  : (out_data.resolved_node != '0)))
    else $error("malformed result");

  // A set transfer gives no result.
  a_set_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.func == lcr_pkg::FUNC_SET) && !out_valid)
    |=> !out_valid)
    else $error("result after set item");

  // A push only happens when the output register can take it.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_data) && out_valid))
    else $error("waiting result overwritten");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int          TABLE_SIZE   = 256;
  localparam logic [2:0]  ADDR_NODE_COUNT = 3'd0;
  localparam int          SET_SETTLE   = 16;
  localparam int          END_SETTLE   = 2 * TABLE_SIZE + 16;
  localparam longint      CYCLE_LIMIT  = 3000000;

  typedef enum int {CHAIN_END_EMPTY, CHAIN_END_LOOP, CHAIN_END_BAD} chain_end_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  lcr_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  lcr_pkg::out_item_t out_data;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  link_chain_resolver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow copy of the block's state; the tables advance at every accepted input transfer.
  logic [8:0]  link_tbl [TABLE_SIZE];
  bit          err_tbl [TABLE_SIZE];
  logic [8:0]  node_limit = 9'd256;

  lcr_pkg::in_item_t  pending_items[$];
  lcr_pkg::out_item_t expected_answers[$];

  bit          in_xfer;
  longint      cycle_count;
  int          fail_count;
  int          items_queued;
  int          transfers_in;
  int          results_checked;
  int          error_results;
  int          longest_walk;
  int          settings_used;
  int          burst_left;
  int          gap_left;
  int          stall_left;
  stall_mode_t stall_mode = STALL_NONE;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 20) begin
      $display("MISMATCH at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
    end
    fail_count++;
  endtask

  function automatic int active_nodes();
    return (node_limit > TABLE_SIZE) ? TABLE_SIZE : int'(node_limit);
  endfunction

  // Applies one input item to the shadow table; a resolve walks the links,
  // compresses or error-marks the path, and queues the answer.
  function automatic void predict_item(lcr_pkg::in_item_t it);
    int                 cnt;
    int                 cur;
    int                 nxt;
    int                 steps;
    int                 walk[$];
    bit                 seen [TABLE_SIZE];
    bit                 failed;
    int                 answer;
    lcr_pkg::out_item_t res;
    cnt = active_nodes();
    if (it.func == lcr_pkg::FUNC_SET) begin
      if (it.node >= 1 && it.node <= cnt) begin
        link_tbl[it.node - 1] = it.target;
        err_tbl[it.node - 1] = 1'b0;
      end
    end else begin
      failed = 1'b1;
      answer = 0;
      cur = int'(it.node);
      if (cur >= 1 && cur <= cnt) begin
        for (steps = 0; steps <= cnt; steps++) begin
          if (cur < 1 || cur > cnt || err_tbl[cur - 1]) break;
          nxt = int'(link_tbl[cur - 1]);
          if (nxt == 0) begin
            failed = 1'b0;
            answer = cur;
            break;
          end
          if (nxt == cur || seen[cur - 1]) break;
          walk.push_back(cur);
          seen[cur - 1] = 1'b1;
          cur = nxt;
        end
        foreach (walk[k]) begin
          if (failed) begin
            err_tbl[walk[k] - 1] = 1'b1;
          end else begin
            link_tbl[walk[k] - 1] = answer[8:0];
          end
        end
        if (walk.size() > longest_walk) longest_walk = walk.size();
      end
      res.resolved_node = answer[8:0];
      res.error = failed;
      expected_answers.push_back(res);
    end
  endfunction

  // Result check and input prediction share one block so their order is fixed.
  always @(posedge clk) begin
    lcr_pkg::out_item_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      in_xfer = rst_n && in_valid && !in_stall;
      if (rst_n && out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result, node", 32'(out_data.resolved_node), 0);
        end else begin
          want = expected_answers.pop_front();
          results_checked++;
          if (want.error) error_results++;
          if (out_data.resolved_node !== want.resolved_node) begin
            report_mismatch("resolved_node", 32'(out_data.resolved_node),
                            32'(want.resolved_node));
          end
          if (out_data.error !== want.error) begin
            report_mismatch("error", 32'(out_data.error), 32'(want.error));
          end
        end
      end
      if (in_xfer) begin
        transfers_in++;
        predict_item(in_data);
      end
    end
  end

  // Sender: bursts of random length separated by random gaps, some of them empty.
  always @(negedge clk) begin
    logic              nv;
    lcr_pkg::in_item_t nd;
    nv = in_valid;
    nd = in_data;
    if (in_xfer) nv = 1'b0;
    if (!nv && pending_items.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        nd = pending_items.pop_front();
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // Receiver: stall behavior switches among several modes over time.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:      out_stall <= 1'b0;
      STALL_LIGHT:     out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:     out_stall <= ($urandom_range(0, 15) != 0);
      default:         out_stall <= ~out_stall;
    endcase
  end

  task automatic push_link(input int node, input int target);
    lcr_pkg::in_item_t it;
    it.func = lcr_pkg::FUNC_SET;
    it.node = node[8:0];
    it.target = target[8:0];
    pending_items.push_back(it);
    items_queued++;
  endtask

  // The target field is ignored on a resolve, so it carries random bits.
  task automatic push_lookup(input int node);
    lcr_pkg::in_item_t it;
    it.func = lcr_pkg::FUNC_RESOLVE;
    it.node = node[8:0];
    it.target = 9'($urandom_range(0, 511));
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Builds a chain over distinct nodes, ends it as asked, then resolves inside it.
  task automatic add_chain(input int len, input chain_end_t ending);
    int cnt;
    int nodes[$];
    bit used [TABLE_SIZE + 1];
    int n;
    cnt = active_nodes();
    while (nodes.size() < len) begin
      n = $urandom_range(1, cnt);
      if (!used[n]) begin
        used[n] = 1'b1;
        nodes.push_back(n);
      end
    end
    for (int k = 0; k < len - 1; k++) push_link(nodes[k], nodes[k + 1]);
    case (ending)
      CHAIN_END_EMPTY: push_link(nodes[len - 1], 0);
      CHAIN_END_LOOP:  push_link(nodes[len - 1], nodes[$urandom_range(0, len - 1)]);
      default:         push_link(nodes[len - 1], $urandom_range(cnt + 1, 511));
    endcase
    push_lookup(nodes[$urandom_range(0, len - 1)]);
    if ($urandom_range(0, 1) == 1) push_lookup(nodes[$urandom_range(0, len - 1)]);
  endtask

  function automatic int pick_node();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, active_nodes());
  endfunction

  task automatic add_random_phase(input int budget);
    int stop_at;
    int cnt;
    int sel;
    int len;
    chain_end_t ending;
    stop_at = items_queued + budget;
    cnt = active_nodes();
    while (items_queued < stop_at) begin
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        len = $urandom_range(1, (cnt < 16) ? cnt : 16);
        case ($urandom_range(0, 5))
          4:       ending = CHAIN_END_LOOP;
          5:       ending = CHAIN_END_BAD;
          default: ending = CHAIN_END_EMPTY;
        endcase
        add_chain(len, ending);
      end else if (sel <= 7) begin
        push_lookup(pick_node());
      end else if (sel == 8) begin
        push_link(pick_node(),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, cnt));
      end else begin
        push_link(pick_node(), 0);
      end
    end
  endtask

  // Holds off until every queued item is taken and every result is back.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_answers.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_node_count(input int value);
    logic [31:0] readback;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_NODE_COUNT;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback[8:0] !== value[8:0]) report_mismatch("node_count readback", readback, value);
    node_limit = value[8:0];
    settings_used++;
  endtask

  initial begin
    int settings[$] = '{1, 2, 7, 40};
    foreach (link_tbl[i]) begin
      link_tbl[i] = '0;
      err_tbl[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_node_count(256);
    push_lookup(1);
    push_lookup(256);
    push_lookup(0);
    push_lookup(511);
    push_link(0, 5);
    push_link(2, 3);
    push_link(3, 4);
    push_lookup(2);
    push_lookup(3);
    push_link(5, 5);
    push_link(6, 5);
    push_lookup(6);
    push_lookup(5);
    push_link(7, 8);
    push_link(8, 7);
    push_lookup(7);
    push_link(9, 300);
    push_lookup(9);
    push_link(256, 511);
    push_lookup(256);
    push_link(7, 0);
    push_lookup(7);
    push_lookup(8);
    add_random_phase(170);

    // A set gives no result, so the bench waits before each register write.
    foreach (settings[s]) begin
      drain();
      repeat (SET_SETTLE) @(negedge clk);
      write_node_count(settings[s]);
      add_random_phase(170);
    end

    drain();
    repeat (SET_SETTLE) @(negedge clk);
    write_node_count(256);
    add_chain(256, CHAIN_END_EMPTY);
    add_random_phase(40);

    drain();
    repeat (END_SETTLE) @(negedge clk);
    $display("Covered %0d input transfers over %0d node_count settings; longest walk %0d links.",
             transfers_in, settings_used, longest_walk);
    $display("Checked %0d results, %0d of them errors; %0d mismatches.",
             results_checked, error_results, fail_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
